/* hdl/jddm_pkg.sv */
// Package for the joystick differential-drive mixer: payload structs,
// mode codes and fixed offsets. No dependencies.
`default_nettype none
package jddm_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] axis_x;
    logic [12:0] axis_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_duty;
    logic [15:0] right_duty;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_NEUTRAL   = 3'd1,
    MODE_STRAIGHT  = 3'd2,
    MODE_SPIN      = 3'd3,
    MODE_FWD_LEFT  = 3'd4,
    MODE_FWD_RIGHT = 3'd5,
    MODE_REV_LEFT  = 3'd6,
    MODE_REV_RIGHT = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_DUTY_MAX     = 2'd0,
    REG_DUTY_MIN     = 2'd1,
    REG_DUTY_NEUTRAL = 2'd2
  } reg_idx_t;

  localparam int AXIS_MID  = 2048;
  localparam int BASE_DUTY = 3000;

endpackage
`default_nettype wire

/* hdl/joystick_differential_drive_mixer_top.sv */
// Joystick differential-drive mixer.
// Pipeline: ceil((SLOPE_FRAC_BITS+13)/4) divider stages plus four stages.
// Throughput: one transfer per cycle; the whole pipe advances when the
// output register is free. Synchronous active-low reset clears valid bits
// and loads the duty registers with 4200, 1800 and 3000.
`default_nettype none
module joystick_differential_drive_mixer_top #(
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire jddm_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output jddm_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import jddm_pkg::*;

  localparam int F  = SLOPE_FRAC_BITS;
  localparam int NW = F + 13;
  localparam int DS = (NW + 3) / 4;
  localparam int KW = NW + 1;

  logic [15:0] dmax_r, dmin_r, dneu_r;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmax_r <= 16'd4200;
      dmin_r <= 16'd1800;
      dneu_r <= 16'd3000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DUTY_MAX:     dmax_r <= cfg_data;
        REG_DUTY_MIN:     dmin_r <= cfg_data;
        REG_DUTY_NEUTRAL: dneu_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances whenever the output is free
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [DS+2:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[DS+1:0], in_valid};
  end

  // Stage 0 into divider: magnitudes and signs
  logic signed [13:0] dx, dy;
  assign dx = $signed({1'b0, in_data.axis_x}) - 14'sd2048;
  assign dy = $signed({1'b0, in_data.axis_y}) - 14'sd2048;
  logic [12:0] dxm;
  logic [12:0] dym;
  assign dxm = dx[13] ? 13'(-dx) : dx[12:0];
  assign dym = dy[13] ? 13'(-dy) : dy[12:0];
  logic [NW-1:0] num;
  assign num = (dx == 14'sd0) ? '0 : {dym, F'(0)};
  logic [12:0] den;
  assign den = (dx == 14'sd0) ? 13'd1 : dxm;

  localparam int TW = 3 + 13 + 13 + 1;
  logic [NW-1:0] qm;
  logic [TW-1:0] tg;
  jddm_div #(.NW(NW), .SW(4), .TW(TW)) u_div (
    .clk(clk), .en(adv), .num_mag(num), .den_mag(den),
    .tag_in({in_data.mode, in_data.axis_x, in_data.axis_y, dx[13] ^ dy[13]}),
    .quo_mag(qm), .tag_out(tg)
  );

  in_item_t d_it;
  assign d_it = in_item_t'(tg[TW-1:1]);
  logic signed [KW-1:0] k;
  assign k = tg[0] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

  // Stage A: slope product, linear product, comparison flags
  logic [2:0]  a_mode_r;
  logic [12:0] a_x_r, a_y_r;
  logic signed [KW+10:0] a_kp_r;
  logic        a_kgt_r, a_klt_r;
  logic signed [31:0] a_lin_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_mode_r <= d_it.mode;
      a_x_r    <= d_it.axis_x;
      a_y_r    <= d_it.axis_y;
      a_kp_r   <= (KW+11)'(k) * (KW+11)'(1000);
      a_kgt_r  <= k > (KW)'(1 << F);
      a_klt_r  <= k < -(KW)'(1 << F);
      a_lin_r  <= ($signed({1'b0, dmax_r}) - $signed({1'b0, dmin_r}))
                * (d_it.mode == MODE_SPIN
                   ? 32'sd4096 - $signed({19'd0, d_it.axis_x})
                   : 32'sd4096 - $signed({19'd0, d_it.axis_y}));
    end
  end

  // Stage B: saturated slope term and raw diagonal values (Q8)
  logic signed [F+16:0] base1;
  assign base1 = (F+17)'(BASE_DUTY) <<< F;
  logic signed [KW+12:0] sp, sn;
  assign sp = (KW+13)'(base1) + (KW+13)'(a_kp_r);
  assign sn = (KW+13)'(base1) - (KW+13)'(a_kp_r);
  function automatic logic signed [25:0] satq(input logic signed [KW+12:0] v);
    logic signed [KW+12:0] q;
    q = v >>> F;
    if (v < 0) return '0;
    if (q > 65535) return 26'sd65535 <<< 8;
    return 26'(q) <<< 8;
  endfunction
  logic signed [25:0] ax;
  logic signed [25:0] ay;
  assign ax = ($signed({13'd0, a_x_r}) - 26'sd2048) * 26'sd125;
  assign ay = ($signed({13'd0, a_y_r}) - 26'sd2048) * 26'sd125;

  logic [2:0] b_mode_r;
  logic signed [26:0] b_l_r, b_r_r;
  logic signed [31:0] b_lin_r;
  logic [15:0] b_dmx_r, b_dmn_r, b_neu_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode_r <= a_mode_r;
      b_lin_r  <= a_lin_r;
      b_dmx_r  <= dmax_r;
      b_dmn_r  <= dmin_r;
      b_neu_r  <= dneu_r;
      unique case (mode_t'(a_mode_r))
        MODE_FWD_LEFT: begin
          b_r_r <= a_kgt_r ? 27'((3800 * 256) - ax) : 27'((3300 * 256) - ay);
          b_l_r <= 27'(satq(sp)) - 27'(1200 * 256);
        end
        MODE_FWD_RIGHT: begin
          b_l_r <= a_klt_r ? 27'((4200 * 256) + ax) : 27'((4200 * 256) - ay);
          b_r_r <= 27'(satq(sn)) - 27'(1200 * 256);
        end
        MODE_REV_LEFT: begin
          b_l_r <= a_klt_r ? 27'((1800 * 256) + ax) : 27'((1800 * 256) + ay);
          b_r_r <= 27'(satq(sp)) + 27'(1200 * 256);
        end
        default: begin
          b_r_r <= a_kgt_r ? 27'((1150 * 256) + ay) : 27'((2900 * 256) - ax);
          b_l_r <= 27'(satq(sn)) + 27'(1600 * 256);
        end
      endcase
    end
  end

  // Stage C: clamp and select by mode
  function automatic logic signed [26:0] clampq(input logic signed [26:0] v,
                                              input logic [15:0] mx,
                                              input logic [15:0] mn);
    logic signed [26:0] o;
    o = v;
    if (o > $signed({3'd0, mx, 8'd0})) o = $signed({3'd0, mx, 8'd0});
    if (o < $signed({3'd0, mn, 8'd0})) o = $signed({3'd0, mn, 8'd0});
    return o;
  endfunction
  function automatic logic [15:0] sat12(input logic signed [33:0] v);
    if (v < 0) return 16'd0;
    if ((v >>> 12) > 34'sd65535) return 16'hFFFF;
    return 16'(v >>> 12);
  endfunction
  logic signed [26:0] cl, cr;
  assign cl = clampq(b_l_r, b_dmx_r, b_dmn_r);
  assign cr = clampq(b_r_r, b_dmx_r, b_dmn_r);
  logic signed [33:0] mn12, mx12;
  assign mn12 = $signed({6'd0, b_dmn_r, 12'd0});
  assign mx12 = $signed({6'd0, b_dmx_r, 12'd0});

  logic       c_keep_r;
  out_item_t  c_o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (mode_t'(b_mode_r))
        MODE_NONE: begin
          c_keep_r <= 1'b0;
          c_o_r    <= '0;
        end
        MODE_NEUTRAL: begin
          c_keep_r <= 1'b1;
          c_o_r    <= '{b_neu_r, b_neu_r};
        end
        MODE_STRAIGHT: begin
          c_keep_r <= 1'b1;
          c_o_r <= '{sat12(mn12 + 34'(b_lin_r)), sat12(mn12 + 34'(b_lin_r))};
        end
        MODE_SPIN: begin
          c_keep_r <= 1'b1;
          c_o_r <= '{sat12(mx12 - 34'(b_lin_r)), sat12(mn12 + 34'(b_lin_r))};
        end
        default: begin
          c_keep_r <= !((b_mode_r == MODE_FWD_LEFT && cl > cr)
                     || (b_mode_r == MODE_REV_RIGHT && cr > cl));
          c_o_r <= '{(cl < 0) ? 16'd0 : cl[23:8], (cr < 0) ? 16'd0 : cr[23:8]};
        end
      endcase
    end
  end

  // Output register: drop items with no result
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= v_r[DS+2] && c_keep_r;
  end
  always_ff @(posedge clk) begin
    if (adv) out_data <= c_o_r;
  end
endmodule
`default_nettype wire

/* hdl/jddm_div.sv */
// Pipelined restoring divider: unsigned numerator magnitude over unsigned
// 13 bit denominator magnitude, quotient truncated toward zero. Uses nothing else.
`default_nettype none
module jddm_div #(
  parameter int NW = 30,
  parameter int SW = 4,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_mag,
  input  wire logic [12:0]   den_mag,
  input  wire logic [TW-1:0] tag_in,
  output logic [NW-1:0]      quo_mag,
  output logic [TW-1:0]      tag_out
);
  // Each stage resolves SW quotient bits.
  localparam int NST = (NW + SW - 1) / SW;
  localparam int PW  = NST * SW;

  logic [PW-1:0] q_r   [1:NST];
  logic [TW-1:0] t_r   [1:NST];
  logic [13:0]   rem_r [1:NST-1];
  logic [12:0]   d_r   [1:NST-1];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [PW-1:0] q_in;
    logic [13:0]   rem_in;
    logic [12:0]   d_in;
    logic [TW-1:0] t_in;
    logic [PW-1:0] q_nxt;
    logic [13:0]   rem_nxt;

    // Take the operands from the ports at the head, else from the stage before
    if (s == 0) begin : g_head
      assign q_in   = PW'(num_mag);
      assign rem_in = '0;
      assign d_in   = den_mag;
      assign t_in   = tag_in;
    end else begin : g_body
      assign q_in   = q_r[s];
      assign rem_in = rem_r[s];
      assign d_in   = d_r[s];
      assign t_in   = t_r[s];
    end

    always_comb begin
      logic [14:0] tr;
      q_nxt   = q_in;
      rem_nxt = rem_in;
      for (int b = 0; b < SW; b++) begin
        tr = {rem_nxt, q_nxt[PW-1]};
        q_nxt = {q_nxt[PW-2:0], 1'b0};
        if (tr >= {2'b0, d_in}) begin
          rem_nxt  = 14'(tr - {2'b0, d_in});
          q_nxt[0] = 1'b1;
        end else begin
          rem_nxt = tr[13:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_nxt;
        t_r[s+1] <= t_in;
      end
    end

    // Carry remainder and divisor only where a later stage reads them
    if (s < NST - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          d_r[s+1]   <= d_in;
        end
      end
    end
  end

  assign quo_mag = q_r[NST][NW-1:0];
  assign tag_out = t_r[NST];
endmodule
`default_nettype wire

/* hdl/jddm_checker.sv */
// Port-level checker for the mixer top level, bound by the statement below.
// Depends on jddm_pkg.
`default_nettype none
module jddm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire jddm_pkg::out_item_t out_data
);
  import jddm_pkg::*;

  // A pending result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // Input stalls only when the output is full and stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");
  // A stalled input transfer stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input withdrawn under stall");
  // Reset leaves no result
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind joystick_differential_drive_mixer_top jddm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
